FILE: src/rsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the running statistics block.
package rsc_pkg;

   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int COUNT_BITS_DEF    = 16;
   localparam int SAMPLE_FIELD_BITS = 24;
   localparam int COUNT_FIELD_BITS  = 16;
   localparam int INDEX_BITS        = 17;
   localparam int ACC_BITS          = 16;
   localparam int ACC_FRAC_BITS     = 16;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_ERASE = 1'b1;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_ERASE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                         op;
      logic [SAMPLE_FIELD_BITS-1:0]   sample;
   } item_type;

endpackage

FILE: src/rsc_channels.sv
`timescale 1ns / 1ps
// Handshake channel interfaces for request, response and register write.
interface rsc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [23:0] sample;
   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface rsc_rsp_if;
   logic               valid;
   logic               ready;
   logic               converged;
   logic [15:0]        sample_count;
   logic [23:0]        mean_value;
   logic [23:0]        std_dev;
   logic [23:0]        min_value;
   logic [23:0]        max_value;
   logic signed [16:0] min_index;
   logic signed [16:0] max_index;
   logic               overflow;
   modport source (output valid, output converged, output sample_count, output mean_value,
                   output std_dev, output min_value, output max_value, output min_index,
                   output max_index, output overflow, input ready);
   modport sink   (input valid, input converged, input sample_count, input mean_value,
                   input std_dev, input min_value, input max_value, input min_index,
                   input max_index, input overflow, output ready);
endinterface

interface rsc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/rsc_front.sv
`timescale 1ns / 1ps
// Front stage: accept request beats, decode the command, register the item.
module rsc_front (
   input  logic              clock,
   input  logic              reset,
   rsc_req_if.sink           req,
   output logic              push_valid,
   output rsc_pkg::item_type push_item,
   input  logic              push_ready
);
   import rsc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   op_type   op_dec;

   always_comb begin
      unique case (req.cmd)
         CMD_ERASE: op_dec = OP_ERASE;
         default:   op_dec = OP_ADD;
      endcase
   end

   assign req.ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff && !push_ready;
      item_in  = item_ff;
      if (req.valid && req.ready) begin
         valid_in       = 1'b1;
         item_in.op     = op_dec;
         item_in.sample = req.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: src/rsc_queue.sv
`timescale 1ns / 1ps
// Two-entry item queue between the front and back stages.
module rsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  rsc_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output rsc_pkg::item_type pop_item,
   input  logic              pop
);
   import rsc_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/rsc_back.sv
`timescale 1ns / 1ps
// Back stage: statistics state, shared shift-add multiplier, root and divide sequencer.
module rsc_back #(
   parameter int SAMPLE_BITS = rsc_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rsc_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rsc_pkg::ACC_BITS-1:0]  accuracy,
   input  logic                          q_valid,
   input  rsc_pkg::item_type             q_item,
   output logic                          q_pop,
   rsc_rsp_if.source                     rsp
);
   import rsc_pkg::*;

   localparam int S    = SAMPLE_BITS;
   localparam int C    = COUNT_BITS;
   localparam int SC   = S + C;
   localparam int SQ   = 2 * S + C;
   localparam int DW   = 2 * SC;
   localparam int AW   = ACC_BITS + C + 1;
   localparam int PW   = (DW > SC + AW) ? DW : SC + AW;
   localparam int STW  = $clog2(SC + 1);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_DISP  = 13'b0000000000010,
      ST_MNV   = 13'b0000000000100,
      ST_MACC  = 13'b0000000001000,
      ST_MSA   = 13'b0000000010000,
      ST_UPD   = 13'b0000000100000,
      ST_STAT  = 13'b0000001000000,
      ST_MNQ   = 13'b0000010000000,
      ST_MSS   = 13'b0000100000000,
      ST_SQRT  = 13'b0001000000000,
      ST_DSTD  = 13'b0010000000000,
      ST_DMEAN = 13'b0100000000000,
      ST_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [SC-1:0]         sum_ff, sum_in;
   logic [SQ-1:0]         sq_ff, sq_in;
   logic [C-1:0]          cnt_ff, cnt_in;
   logic                  conv_ff, conv_in;
   logic [S-1:0]          min_ff, min_in, max_ff, max_in;
   logic [INDEX_BITS-1:0] minpos_ff, minpos_in, maxpos_ff, maxpos_in;
   logic [S-1:0]          mean_ff, mean_in, std_ff, std_in;

   op_type                op_ff, op_in;
   logic [S-1:0]          v_ff, v_in;
   logic                  ovf_ff, ovf_in;

   logic [PW-1:0]         ma_ff, ma_in, mp_ff, mp_in, tmp_ff, tmp_in;
   logic [SC-1:0]         mb_ff, mb_in;
   logic [SC-1:0]         diff_ff, diff_in;
   logic [DW-1:0]         rad_ff, rad_in;
   logic [SC+1:0]         rem_ff, rem_in;
   logic [SC-1:0]         root_ff, root_in;
   logic [SC-1:0]         dq_ff, dq_in;
   logic [C:0]            dr_ff, dr_in;
   logic [STW-1:0]        step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  o_conv_ff, o_conv_in, o_ovf_ff, o_ovf_in;
   logic [C-1:0]          o_cnt_ff, o_cnt_in;
   logic [S-1:0]          o_mean_ff, o_mean_in, o_std_ff, o_std_in;
   logic [S-1:0]          o_min_ff, o_min_in, o_max_ff, o_max_in;
   logic [INDEX_BITS-1:0] o_minpos_ff, o_minpos_in, o_maxpos_ff, o_maxpos_in;

   logic                  mul_done;
   logic [PW-1:0]         mul_next;
   logic [SC-1:0]         nv;
   logic [SC+1:0]         rem_t, trial;
   logic [C:0]            div_t;
   logic [2*S-1:0]        vsq;

   assign mul_done = (mb_ff == '0);
   assign mul_next = mp_ff + (mb_ff[0] ? ma_ff : '0);
   assign nv       = mp_ff[SC-1:0];
   assign rem_t    = {rem_ff[SC-1:0], rad_ff[DW-1 -: 2]};
   assign trial    = {root_ff, 2'b01};
   assign div_t    = {dr_ff[C-1:0], dq_ff[SC-1]};
   assign vsq      = v_ff * v_ff;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      cnt_in       = cnt_ff;
      conv_in      = conv_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      minpos_in    = minpos_ff;
      maxpos_in    = maxpos_ff;
      mean_in      = mean_ff;
      std_in       = std_ff;
      op_in        = op_ff;
      v_in         = v_ff;
      ovf_in       = ovf_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mp_in        = mp_ff;
      tmp_in       = tmp_ff;
      diff_in      = diff_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      o_conv_in    = o_conv_ff;
      o_ovf_in     = o_ovf_ff;
      o_cnt_in     = o_cnt_ff;
      o_mean_in    = o_mean_ff;
      o_std_in     = o_std_ff;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      o_minpos_in  = o_minpos_ff;
      o_maxpos_in  = o_maxpos_ff;
      q_pop        = 1'b0;

      if (!mul_done) begin
         mp_in = mul_next;
         ma_in = ma_ff << 1;
         mb_in = mb_ff >> 1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               op_in    = q_item.op;
               v_in     = q_item.sample[S-1:0];
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            ovf_in = 1'b0;
            if (op_ff == OP_ERASE) begin
               sum_in    = '0;
               sq_in     = '0;
               cnt_in    = '0;
               conv_in   = 1'b0;
               min_in    = '1;
               max_in    = '0;
               minpos_in = '1;
               maxpos_in = '1;
               mean_in   = '0;
               std_in    = '0;
               state_in  = ST_OUT;
            end else if (cnt_ff == '1) begin
               ovf_in   = 1'b1;
               state_in = ST_OUT;
            end else if (cnt_ff >= C'(2)) begin
               ma_in    = PW'(v_ff);
               mb_in    = SC'(cnt_ff);
               mp_in    = '0;
               state_in = ST_MNV;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_MNV: begin
            if (mul_done) begin
               diff_in  = (nv >= sum_ff) ? nv - sum_ff : sum_ff - nv;
               ma_in    = PW'(accuracy);
               mb_in    = SC'({1'b0, cnt_ff} + (C+1)'(1));
               mp_in    = '0;
               state_in = ST_MACC;
            end
         end
         ST_MACC: begin
            if (mul_done) begin
               ma_in    = mp_ff;
               mb_in    = sum_ff;
               mp_in    = '0;
               state_in = ST_MSA;
            end
         end
         ST_MSA: begin
            if (mul_done) begin
               conv_in  = mp_ff > PW'({diff_ff, {ACC_FRAC_BITS{1'b0}}});
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (cnt_ff == '0 || v_ff < min_ff) begin
               min_in    = v_ff;
               minpos_in = INDEX_BITS'(cnt_ff);
            end
            if (cnt_ff == '0 || v_ff > max_ff) begin
               max_in    = v_ff;
               maxpos_in = INDEX_BITS'(cnt_ff);
            end
            sum_in   = sum_ff + SC'(v_ff);
            sq_in    = sq_ff + SQ'(vsq);
            cnt_in   = cnt_ff + C'(1);
            state_in = ST_STAT;
         end
         ST_STAT: begin
            ma_in    = PW'(sq_ff);
            mb_in    = SC'(cnt_ff);
            mp_in    = '0;
            state_in = ST_MNQ;
         end
         ST_MNQ: begin
            if (mul_done) begin
               tmp_in   = mp_ff;
               ma_in    = PW'(sum_ff);
               mb_in    = sum_ff;
               mp_in    = '0;
               state_in = ST_MSS;
            end
         end
         ST_MSS: begin
            if (mul_done) begin
               rad_in   = (tmp_ff > mp_ff) ? DW'(tmp_ff - mp_ff) : '0;
               rem_in   = '0;
               root_in  = '0;
               step_in  = STW'(SC);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (step_ff != '0) begin
               rad_in  = rad_ff << 2;
               step_in = step_ff - STW'(1);
               if (rem_t >= trial) begin
                  rem_in  = rem_t - trial;
                  root_in = {root_ff[SC-2:0], 1'b1};
               end else begin
                  rem_in  = rem_t;
                  root_in = {root_ff[SC-2:0], 1'b0};
               end
            end else begin
               dq_in    = root_ff;
               dr_in    = '0;
               step_in  = STW'(SC);
               state_in = ST_DSTD;
            end
         end
         ST_DSTD, ST_DMEAN: begin
            if (step_ff != '0) begin
               step_in = step_ff - STW'(1);
               if (div_t >= {1'b0, cnt_ff}) begin
                  dr_in = div_t - {1'b0, cnt_ff};
                  dq_in = {dq_ff[SC-2:0], 1'b1};
               end else begin
                  dr_in = div_t;
                  dq_in = {dq_ff[SC-2:0], 1'b0};
               end
            end else if (state_ff == ST_DSTD) begin
               std_in   = dq_ff[S-1:0];
               dq_in    = sum_ff;
               dr_in    = '0;
               step_in  = STW'(SC);
               state_in = ST_DMEAN;
            end else begin
               mean_in  = dq_ff[S-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               o_conv_in    = conv_ff;
               o_ovf_in     = ovf_ff;
               o_cnt_in     = cnt_ff;
               o_mean_in    = mean_ff;
               o_std_in     = std_ff;
               o_min_in     = min_ff;
               o_max_in     = max_ff;
               o_minpos_in  = minpos_ff;
               o_maxpos_in  = maxpos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.converged    = o_conv_ff;
   assign rsp.overflow     = o_ovf_ff;
   assign rsp.sample_count = COUNT_FIELD_BITS'(o_cnt_ff);
   assign rsp.mean_value   = SAMPLE_FIELD_BITS'(o_mean_ff);
   assign rsp.std_dev      = SAMPLE_FIELD_BITS'(o_std_ff);
   assign rsp.min_value    = SAMPLE_FIELD_BITS'(o_min_ff);
   assign rsp.max_value    = SAMPLE_FIELD_BITS'(o_max_ff);
   assign rsp.min_index    = o_minpos_ff;
   assign rsp.max_index    = o_maxpos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         cnt_ff       <= '0;
         conv_ff      <= 1'b0;
         min_ff       <= '1;
         max_ff       <= '0;
         minpos_ff    <= '1;
         maxpos_ff    <= '1;
         mean_ff      <= '0;
         std_ff       <= '0;
         mb_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         cnt_ff       <= cnt_in;
         conv_ff      <= conv_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         minpos_ff    <= minpos_in;
         maxpos_ff    <= maxpos_in;
         mean_ff      <= mean_in;
         std_ff       <= std_in;
         mb_ff        <= mb_in;
      end
      op_ff       <= op_in;
      v_ff        <= v_in;
      ovf_ff      <= ovf_in;
      ma_ff       <= ma_in;
      mp_ff       <= mp_in;
      tmp_ff      <= tmp_in;
      diff_ff     <= diff_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      dq_ff       <= dq_in;
      dr_ff       <= dr_in;
      step_ff     <= step_in;
      o_conv_ff   <= o_conv_in;
      o_ovf_ff    <= o_ovf_in;
      o_cnt_ff    <= o_cnt_in;
      o_mean_ff   <= o_mean_in;
      o_std_ff    <= o_std_in;
      o_min_ff    <= o_min_in;
      o_max_ff    <= o_max_in;
      o_minpos_ff <= o_minpos_in;
      o_maxpos_ff <= o_maxpos_in;
   end

endmodule

FILE: src/running_stats_convergence.sv
`timescale 1ns / 1ps
// Top level of the running statistics and convergence block.
//
//  channel   dir  beat carries
//  req_bus   in   cmd, sample
//  rsp_bus   out  converged, sample_count, mean_value, std_dev, extremes, indices, overflow
//  csr_bus   in   accuracy write data
//
// An add runs through the one-bit-a-cycle multiplier, root and divider of the back stage.
// Erase and dropped samples go from dispatch straight to the output state.
// Reset is synchronous and clears all statistics and the accuracy register.
// Two queued items and one waiting response let the request side run ahead of the back stage.
module running_stats_convergence #(
   parameter int SAMPLE_BITS = rsc_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rsc_pkg::COUNT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rsc_req_if.sink    req_bus,
   rsc_rsp_if.source  rsp_bus,
   rsc_csr_if.sink    csr_bus
);
   import rsc_pkg::*;

   logic [ACC_BITS-1:0] accuracy_ff, accuracy_in;
   logic                push_valid, push_ready, pop_valid, pop;
   item_type            push_item, pop_item;

   assign csr_bus.ready = 1'b1;
   assign accuracy_in   = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : accuracy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accuracy_ff <= '0;
      end else begin
         accuracy_ff <= accuracy_in;
      end
   end

   rsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   rsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   rsc_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .accuracy (accuracy_ff),
      .q_valid  (pop_valid),
      .q_item   (pop_item),
      .q_pop    (pop),
      .rsp      (rsp_bus)
   );

endmodule

FILE: src/rsc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the running statistics block and their bind.
module rsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [15:0]        sample_count,
   input logic [23:0]        mean_value,
   input logic [23:0]        std_dev,
   input logic [23:0]        min_value,
   input logic [23:0]        max_value,
   input logic signed [16:0] min_index,
   input logic signed [16:0] max_index,
   input logic               overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_count))
      else $error("response dropped or changed while stalled");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sample_count == 16'd0 |->
         mean_value == 24'd0 && std_dev == 24'd0 && max_value == 24'd0 &&
         min_index == -17'sd1 && max_index == -17'sd1)
      else $error("empty statistics not at reset values");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sample_count != 16'd0 |->
         min_value <= mean_value && mean_value <= max_value)
      else $error("mean outside extremes");

   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sample_count != 16'd0 |->
         min_index >= 17'sd0 && max_index >= 17'sd0 &&
         min_index < $signed({1'b0, sample_count}) &&
         max_index < $signed({1'b0, sample_count}))
      else $error("extreme index outside sample range");

   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow |-> sample_count != 16'd0)
      else $error("overflow with empty statistics");

endmodule

bind running_stats_convergence rsc_checker u_rsc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .sample_count (rsp_bus.sample_count),
   .mean_value   (rsp_bus.mean_value),
   .std_dev      (rsp_bus.std_dev),
   .min_value    (rsp_bus.min_value),
   .max_value    (rsp_bus.max_value),
   .min_index    (rsp_bus.min_index),
   .max_index    (rsp_bus.max_index),
   .overflow     (rsp_bus.overflow)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the running statistics and convergence block.
module tb_top;
   import rsc_pkg::*;

   localparam int CFULL = 65535;

   typedef struct packed {
      logic               converged;
      logic [15:0]        sample_count;
      logic [23:0]        mean_value;
      logic [23:0]        std_dev;
      logic [23:0]        min_value;
      logic [23:0]        max_value;
      logic signed [16:0] min_index;
      logic signed [16:0] max_index;
      logic               overflow;
   } stats_type;

   class stats_scoreboard;
      logic [15:0]  accuracy;
      logic [39:0]  sum_total;
      logic [63:0]  sum_sq;
      logic [15:0]  count;
      logic         conv;
      logic [23:0]  min_v, max_v;
      logic [16:0]  min_i, max_i;
      stats_type    pending[$];
      int           errors;
      int           checked;

      function void clear_stats();
         sum_total = 0; sum_sq = 0; count = 0; conv = 0;
         min_v = '1; max_v = 0; min_i = '1; max_i = '1;
      endfunction

      function logic [23:0] root_of_spread();
         logic [127:0] a, b, d, p;
         logic [63:0]  t;
         logic [23:0]  k;
         k = 0;
         if (count == 0) return 0;
         a = 128'(count) * 128'(sum_sq);
         b = 128'(sum_total) * 128'(sum_total);
         if (a <= b) return 0;
         d = a - b;
         for (int bit_n = 23; bit_n >= 0; bit_n--) begin
            t = 64'(k | (24'd1 << bit_n)) * 64'(count);
            p = 128'(t) * 128'(t);
            if (p <= d) k = k | (24'd1 << bit_n);
         end
         return k;
      endfunction

      function void note_item(op_type op, logic [23:0] v);
         stats_type e;
         logic [63:0] nv, diff, lhs, a;
         e.overflow = 0;
         if (op == OP_ERASE) begin
            clear_stats();
         end else if (count >= CFULL) begin
            e.overflow = 1;
         end else begin
            if (count >= 2) begin
               nv = 64'(count) * 64'(v);
               diff = (nv >= 64'(sum_total)) ? nv - sum_total : 64'(sum_total) - nv;
               lhs = diff << 16;
               a = 64'(accuracy) * (64'(count) + 1);
               conv = (a != 0) && (64'(sum_total) > lhs / a);
            end
            if (count == 0 || v < min_v) begin min_v = v; min_i = {1'b0, count}; end
            if (count == 0 || v > max_v) begin max_v = v; max_i = {1'b0, count}; end
            sum_total += v;
            sum_sq += 64'(v) * 64'(v);
            count++;
         end
         e.converged = conv;
         e.sample_count = count;
         e.mean_value = (count != 0) ? 24'(sum_total / count) : 24'd0;
         e.std_dev = root_of_spread();
         e.min_value = min_v; e.max_value = max_v;
         e.min_index = min_i; e.max_index = max_i;
         pending.push_back(e);
      endfunction

      function void check_result(stats_type got);
         stats_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, got);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   rsc_req_if req_bus();
   rsc_rsp_if rsp_bus();
   rsc_csr_if csr_bus();

   running_stats_convergence dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   stats_scoreboard sb;
   int unsigned cycles;
   int unsigned erases, adds, converged_seen, overflow_seen;
   int unsigned burst_left, gap_left;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 2500000) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver: stalls on its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            stats_type g;
            g.converged = rsp_bus.converged; g.sample_count = rsp_bus.sample_count;
            g.mean_value = rsp_bus.mean_value; g.std_dev = rsp_bus.std_dev;
            g.min_value = rsp_bus.min_value; g.max_value = rsp_bus.max_value;
            g.min_index = rsp_bus.min_index; g.max_index = rsp_bus.max_index;
            g.overflow = rsp_bus.overflow;
            if (g.converged) converged_seen++;
            if (g.overflow) overflow_seen++;
            sb.check_result(g);
         end
         case (cycles[9:8])
            2'd0: rsp_bus.ready <= 1;
            2'd1: rsp_bus.ready <= ($urandom_range(3) != 0);
            2'd2: rsp_bus.ready <= ($urandom_range(3) == 0);
            default: rsp_bus.ready <= cycles[2];
         endcase
      end
   end

   task automatic send_item(op_type op, logic [23:0] v);
      if (gap_left == 0 && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
      end
      if (gap_left > 0) req_bus.valid <= 0;
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      req_bus.valid <= 1;
      req_bus.cmd <= op;
      req_bus.sample <= v;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(op, v);
      if (op == OP_ERASE) erases++; else adds++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic drain(int unsigned extra);
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_accuracy(logic [15:0] val);
      drain(300);
      csr_bus.valid <= 1;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 0;
      sb.accuracy = val;
   endtask

   function automatic logic [23:0] near_value(logic [23:0] base, int unsigned spread);
      return base + 24'($urandom_range(2 * spread)) - 24'(spread);
   endfunction

   initial begin
      logic [23:0] base;
      int unsigned n, spread;
      logic [15:0] acc_set[5];
      sb = new();
      sb.accuracy = 0;
      sb.clear_stats();
      erases = 0; adds = 0; converged_seen = 0; overflow_seen = 0;
      burst_left = 0; gap_left = 0;
      reset <= 1;
      req_bus.valid <= 0; req_bus.cmd <= OP_ADD; req_bus.sample <= 0;
      csr_bus.valid <= 0; csr_bus.data <= 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty state, extremes, zero sum, equal extremes
      send_item(OP_ERASE, 24'hFFFFFF);
      send_item(OP_ADD, 24'hFFFFFF);
      send_item(OP_ADD, 24'hFFFFFF);
      send_item(OP_ADD, 24'h0);
      send_item(OP_ADD, 24'hFFFFFF);
      send_item(OP_ERASE, 24'h0);
      send_item(OP_ADD, 24'h0);
      send_item(OP_ADD, 24'h0);
      send_item(OP_ADD, 24'h0);
      send_item(OP_ADD, 24'h5);
      write_accuracy(16'hFFFF);
      send_item(OP_ERASE, 24'h0);
      for (int i = 0; i < 6; i++) send_item(OP_ADD, 24'd1000 + 24'(i));
      send_item(OP_ADD, 24'hFFFFFF);
      send_item(OP_ADD, 24'h0);
      send_item(OP_ADD, 24'hAAAAAA);
      send_item(OP_ADD, 24'h555555);

      acc_set = '{16'd0, 16'd1, 16'd655, 16'd6553, 16'hFFFF};
      for (int ph = 0; ph < 10; ph++) begin
         write_accuracy(acc_set[ph % 5] ^ ((ph >= 5) ? 16'($urandom_range(63)) : 16'd0));
         send_item(OP_ERASE, 24'($urandom));
         base = 24'($urandom);
         spread = ($urandom_range(1) != 0) ? $urandom_range(2000) : $urandom_range(20);
         n = $urandom_range(60, 120);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
               0: send_item(OP_ADD, 24'($urandom));
               1: send_item(OP_ERASE, 24'($urandom));
               2: send_item(OP_ADD, ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h0);
               default: send_item(OP_ADD, near_value(base, spread));
            endcase
         end
      end

      write_accuracy(16'd300);
      send_item(OP_ERASE, 24'h0);
      send_item(OP_ADD, 24'h123456);

      drain(300);
      $display("adds %0d, erases %0d, results %0d, converged %0d, dropped %0d",
               adds, erases, sb.checked, converged_seen, overflow_seen);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
